>>> rtl/core/ffca_pkg.sv
// ============================================================================
// ffca_pkg
// Shared types and constants for the first-fit coalescing allocator: result
// status codes, register indexes, datapath operation codes and status flags.
// ============================================================================
package ffca_pkg;

    // Field widths of the request and result items
    localparam int SIZE_W   = 40;
    localparam int ALIGN_W  = 31;
    localparam int STATUS_W = 3;

    // Allocation granule minus one (64 KiB)
    localparam logic [16:0] GRAIN_MASK = 17'h0FFFF;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BACK     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FRAG     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FREEDROP = 3'd4;

    // Configuration register indexes (selected by paddr[3])
    localparam logic REG_FRONT_LIMIT = 1'b0;
    localparam logic REG_HEAP_BYTES  = 1'b1;

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DISP,
        OP_RD_IDX,
        OP_RD_IDXM1,
        OP_RD_JM1,
        OP_RD_JP1,
        OP_E1,
        OP_E2,
        OP_FIT,
        OP_IDX_INC,
        OP_SPLIT,
        OP_SHRINK,
        OP_DEL_SETUP,
        OP_INS_WR,
        OP_MV_UP,
        OP_MV_DN,
        OP_DEL_END,
        OP_B1,
        OP_B2,
        OP_B3,
        OP_FCMP,
        OP_PRV,
        OP_F_NEXT,
        OP_F_MRG,
        OP_F_PREV,
        OP_F_INS,
        OP_EMIT
    } dp_op_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic is_free;
        logic pre_done;
        logic idx_end;
        logic idx_zero;
        logic fit;
        logic bef_nz;
        logic aft_nz;
        logic full;
        logic ins_done;
        logic del_done;
        logic gt;
        logic mnext;
        logic mprev;
        logic bump_ok;
        logic gap;
    } dp_stat_t;

endpackage

>>> rtl/core/first_fit_coalescing_allocator_unit.sv
// Timing: a refused or dropped item skips the table walk; other items scan the
// table entry by entry and may shift entries to open or close a slot.
// Throughput: one item at a time, paced by the extent table walk; the
// next is taken once the result is registered, even while it waits on m_axis_tready.
// Reset (aresetn low, synchronous) empties the table, zeroes the bump pointer
// and both configuration registers; no clearing pass is needed.
// ============================================================================
// first_fit_coalescing_allocator_unit
// First-fit heap allocator with a sorted, coalescing free-extent table and a
// bump pointer, configured through an APB-style register port.
// ============================================================================
module first_fit_coalescing_allocator_unit #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 40
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Request channel
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // request_size[39:0], alignment_bytes[70:40], place_at_back[71],
    // block_offset[111:72]
    input  logic [111:0] s_axis_tdata,
    // req_type[0]
    input  logic         s_axis_tuser,
    // Result channel
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // granted_offset[39:0]
    output logic [39:0]  m_axis_tdata,
    // status[2:0]
    output logic [2:0]   m_axis_tuser,
    // Configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import ffca_pkg::*;

    logic [SIZE_W-1:0] front_limit_reg;
    logic [SIZE_W-1:0] heap_bytes_reg;
    dp_op_t            op;
    dp_stat_t          stat;

    assign pready = 1'b1;

    // Register writes on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_limit_reg <= '0;
            heap_bytes_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == REG_HEAP_BYTES) begin
                heap_bytes_reg <= pwdata[SIZE_W-1:0];
            end else begin
                front_limit_reg <= pwdata[SIZE_W-1:0];
            end
        end
    end

    // Register readback
    always_comb begin
        prdata = '0;
        if (paddr[3] == REG_FRONT_LIMIT) begin
            prdata[SIZE_W-1:0] = front_limit_reg;
        end else begin
            prdata[SIZE_W-1:0] = heap_bytes_reg;
        end
    end

    ffca_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_axis_tvalid),
        .s_tready (s_axis_tready),
        .m_tvalid (m_axis_tvalid),
        .m_tready (m_axis_tready),
        .op_o     (op),
        .stat_i   (stat)
    );

    ffca_dp #(
        .MAX_EXTENTS (MAX_EXTENTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .op_i               (op),
        .stat_o             (stat),
        .req_type_i         (s_axis_tuser),
        .request_size_i     (s_axis_tdata[39:0]),
        .alignment_bytes_i  (s_axis_tdata[70:40]),
        .place_at_back_i    (s_axis_tdata[71]),
        .block_offset_i     (s_axis_tdata[111:72]),
        .front_limit_i      (front_limit_reg),
        .status_o           (m_axis_tuser),
        .granted_offset_i_o (m_axis_tdata)
    );

endmodule

>>> rtl/core/ffca_dp.sv
// ============================================================================
// ffca_dp
// Allocator datapath: request registers, free-extent table memory, bump
// pointer, extent arithmetic and the result register. Executes one operation
// per cycle as commanded by the controller.
// ============================================================================
module ffca_dp #(
    parameter int MAX_EXTENTS = 16,
    parameter int ADDR_BITS   = 40
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  ffca_pkg::dp_op_t                  op_i,
    output ffca_pkg::dp_stat_t                stat_o,
    input  logic                              req_type_i,
    input  logic [ffca_pkg::SIZE_W-1:0]       request_size_i,
    input  logic [ffca_pkg::ALIGN_W-1:0]      alignment_bytes_i,
    input  logic                              place_at_back_i,
    input  logic [ffca_pkg::SIZE_W-1:0]       block_offset_i,
    input  logic [ffca_pkg::SIZE_W-1:0]       front_limit_i,
    output logic [ffca_pkg::STATUS_W-1:0]     status_o,
    output logic [ffca_pkg::SIZE_W-1:0]       granted_offset_i_o
);
    import ffca_pkg::*;

    localparam int CW = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
    localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
    localparam int NW = $clog2(MAX_EXTENTS + 1);
    localparam logic [CW-1:0] AMASK    = {CW{1'b1}} >> (CW - ADDR_BITS);
    localparam logic [CW-1:0] GRAIN_M  = CW'(GRAIN_MASK);
    localparam logic [NW-1:0] FULL_CNT = NW'(MAX_EXTENTS);

    // Round x up to a multiple of (am + 1); top bit flags address overflow
    function automatic logic [CW:0] round_to_mask(input logic [CW-1:0] x,
                                                  input logic [CW-1:0] am);
        logic          fail;
        logic [CW-1:0] r;
        fail = 1'b0;
        r    = '0;
        if (x != '0) begin
            if (am > AMASK || x > (AMASK - am)) begin
                fail = 1'b1;
            end else begin
                r = (x + am) & ~am;
            end
        end
        return {fail, r};
    endfunction

    // Free-extent table
    logic [ADDR_BITS-1:0] mem_s [MAX_EXTENTS];
    logic [ADDR_BITS-1:0] mem_l [MAX_EXTENTS];

    // Control state
    logic [NW-1:0] cnt_reg;
    logic [CW-1:0] bump_reg;

    // Request and working registers
    logic                type_reg, back_reg, size_zero_reg, rs_bad_reg;
    logic [CW-1:0]       off_reg, rs_reg, amask_reg, fend_reg;
    logic [NW-1:0]       idx_reg, j_reg, ins_idx_reg;
    logic [CW-1:0]       s_reg, e_reg, b_reg, ae_reg, bef_reg, aft_reg, lim_reg;
    logic                bfail_reg, fit_reg, bump_ok_reg, gap_reg;
    logic [CW-1:0]       ins_s_reg, ins_l_reg;
    logic [CW-1:0]       nxt_s_reg, nxt_l_reg, prv_end_reg, prv_l_reg, mlen_reg;
    logic [CW-1:0]       grant_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [STATUS_W-1:0] out_st_reg;
    logic [SIZE_W-1:0]   out_grant_reg;
    logic [ADDR_BITS-1:0] rd_s_reg, rd_l_reg;

    // Combinational helpers
    logic [CW-1:0]       rd_s_x, rd_l_x, size_x, flimit_x;
    logic [ALIGN_W-1:0]  av;
    logic [CW:0]         rs_res, e1_res, b1_res;
    logic                full, disp_done;
    logic [STATUS_W-1:0] disp_st;
    logic [NW-1:0]       idx_m1, j_m1, j_p1, idx_p1;
    logic                rd_en, wr_s_en, wr_l_en;
    logic [IW-1:0]       rd_addr, wr_addr;
    logic [CW-1:0]       wr_s, wr_l;

    assign rd_s_x   = {{(CW-ADDR_BITS){1'b0}}, rd_s_reg};
    assign rd_l_x   = {{(CW-ADDR_BITS){1'b0}}, rd_l_reg};
    assign size_x   = {{(CW-SIZE_W){1'b0}}, request_size_i};
    assign flimit_x = {{(CW-SIZE_W){1'b0}}, front_limit_i};
    assign full     = (cnt_reg == FULL_CNT);
    assign idx_m1   = idx_reg - 1'b1;
    assign idx_p1   = idx_reg + 1'b1;
    assign j_m1     = j_reg - 1'b1;
    assign j_p1     = j_reg + 1'b1;
    assign rs_res   = round_to_mask(size_x, GRAIN_M);
    assign e1_res   = round_to_mask(rd_s_x, amask_reg);
    assign b1_res   = round_to_mask(bump_reg, amask_reg);

    // Smear alignment minus one into a mask, at least the granule
    always_comb begin
        av = (alignment_bytes_i == '0) ? '0 : alignment_bytes_i - 1'b1;
        av = av | (av >> 1);
        av = av | (av >> 2);
        av = av | (av >> 4);
        av = av | (av >> 8);
        av = av | (av >> 16);
        av = av | ALIGN_W'(GRAIN_MASK);
    end

    // Early outcome of a request before any table scan
    always_comb begin
        disp_done = 1'b0;
        disp_st   = ST_OK;
        if (!type_reg) begin
            if (back_reg) begin
                disp_done = 1'b1;
                disp_st   = ST_BACK;
            end else if (rs_bad_reg) begin
                disp_done = 1'b1;
                disp_st   = ST_NOSPACE;
            end
        end else begin
            if (size_zero_reg) begin
                disp_done = 1'b1;
            end else if (full || off_reg > AMASK || rs_bad_reg ||
                         rs_reg > (AMASK - off_reg)) begin
                disp_done = 1'b1;
                disp_st   = ST_FREEDROP;
            end
        end
    end

    // Table read address
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[IW-1:0];
        case (op_i)
            OP_RD_IDX: begin
                rd_en = 1'b1;
            end
            OP_RD_IDXM1: begin
                rd_en   = 1'b1;
                rd_addr = idx_m1[IW-1:0];
            end
            OP_RD_JM1: begin
                rd_en   = 1'b1;
                rd_addr = j_m1[IW-1:0];
            end
            OP_RD_JP1: begin
                rd_en   = 1'b1;
                rd_addr = j_p1[IW-1:0];
            end
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Table write port
    always_comb begin
        wr_s_en = 1'b0;
        wr_l_en = 1'b0;
        wr_addr = idx_reg[IW-1:0];
        wr_s    = ae_reg;
        wr_l    = aft_reg;
        case (op_i)
            OP_SPLIT: begin
                wr_l_en = 1'b1;
                wr_l    = bef_reg;
            end
            OP_SHRINK: begin
                wr_s_en = 1'b1;
                wr_l_en = 1'b1;
            end
            OP_INS_WR: begin
                wr_s_en = 1'b1;
                wr_l_en = 1'b1;
                wr_addr = ins_idx_reg[IW-1:0];
                wr_s    = ins_s_reg;
                wr_l    = ins_l_reg;
            end
            OP_MV_UP, OP_MV_DN: begin
                wr_s_en = 1'b1;
                wr_l_en = 1'b1;
                wr_addr = j_reg[IW-1:0];
                wr_s    = rd_s_x;
                wr_l    = rd_l_x;
            end
            OP_F_NEXT: begin
                wr_s_en = 1'b1;
                wr_l_en = 1'b1;
                wr_s    = off_reg;
                wr_l    = nxt_l_reg + rs_reg;
            end
            OP_F_MRG: begin
                wr_l_en = 1'b1;
                wr_addr = idx_m1[IW-1:0];
                wr_l    = prv_l_reg + mlen_reg;
            end
            OP_F_PREV: begin
                wr_l_en = 1'b1;
                wr_addr = idx_m1[IW-1:0];
                wr_l    = prv_l_reg + rs_reg;
            end
            default: begin
                wr_s_en = 1'b0;
            end
        endcase
    end

    // Table memory with registered read
    always_ff @(posedge aclk) begin
        if (wr_s_en) begin
            mem_s[wr_addr] <= wr_s[ADDR_BITS-1:0];
        end
        if (wr_l_en) begin
            mem_l[wr_addr] <= wr_l[ADDR_BITS-1:0];
        end
        if (rd_en) begin
            rd_s_reg <= mem_s[rd_addr];
            rd_l_reg <= mem_l[rd_addr];
        end
    end

    // Extent count and bump pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            bump_reg <= '0;
        end else begin
            case (op_i)
                OP_INS_WR:  cnt_reg <= cnt_reg + 1'b1;
                OP_DEL_END: cnt_reg <= cnt_reg - 1'b1;
                OP_B3: begin
                    if (bump_ok_reg) begin
                        bump_reg <= b_reg + rs_reg;
                    end
                end
                default: begin
                    cnt_reg <= cnt_reg;
                end
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        case (op_i)
            OP_LOAD: begin
                type_reg      <= req_type_i;
                back_reg      <= place_at_back_i;
                size_zero_reg <= (request_size_i == '0);
                off_reg       <= {{(CW-SIZE_W){1'b0}}, block_offset_i};
                amask_reg     <= {{(CW-ALIGN_W){1'b0}}, av};
                rs_bad_reg    <= rs_res[CW];
                rs_reg        <= rs_res[CW-1:0];
            end
            OP_DISP: begin
                st_reg    <= disp_st;
                grant_reg <= '0;
                idx_reg   <= '0;
                fend_reg  <= off_reg + rs_reg;
            end
            OP_E1: begin
                s_reg     <= rd_s_x;
                e_reg     <= rd_s_x + rd_l_x;
                bfail_reg <= e1_res[CW];
                b_reg     <= e1_res[CW-1:0];
            end
            OP_E2: begin
                fit_reg <= !bfail_reg && (b_reg < e_reg) && ((e_reg - b_reg) >= rs_reg);
                ae_reg  <= b_reg + rs_reg;
            end
            OP_FIT: begin
                bef_reg   <= b_reg - s_reg;
                aft_reg   <= e_reg - ae_reg;
                grant_reg <= b_reg;
            end
            OP_IDX_INC: idx_reg <= idx_p1;
            OP_SPLIT: begin
                if (aft_reg != '0) begin
                    if (full) begin
                        st_reg <= ST_FRAG;
                    end else begin
                        ins_idx_reg <= idx_p1;
                        ins_s_reg   <= ae_reg;
                        ins_l_reg   <= aft_reg;
                        j_reg       <= cnt_reg;
                    end
                end
            end
            OP_DEL_SETUP: j_reg <= idx_reg;
            OP_MV_UP:     j_reg <= j_m1;
            OP_MV_DN:     j_reg <= j_p1;
            OP_B1: begin
                bfail_reg <= b1_res[CW];
                b_reg     <= b1_res[CW-1:0];
                lim_reg   <= (flimit_x > AMASK) ? AMASK : flimit_x;
            end
            OP_B2: begin
                bump_ok_reg <= !bfail_reg && (b_reg < lim_reg) && (rs_reg <= (lim_reg - b_reg));
                gap_reg     <= (b_reg != bump_reg);
            end
            OP_B3: begin
                if (bump_ok_reg) begin
                    grant_reg <= b_reg;
                    if (gap_reg) begin
                        if (full) begin
                            st_reg <= ST_FRAG;
                        end else begin
                            ins_idx_reg <= cnt_reg;
                            ins_s_reg   <= bump_reg;
                            ins_l_reg   <= b_reg - bump_reg;
                            j_reg       <= cnt_reg;
                        end
                    end
                end else begin
                    st_reg <= ST_NOSPACE;
                end
            end
            OP_FCMP: begin
                if (rd_s_x > off_reg) begin
                    nxt_s_reg <= rd_s_x;
                    nxt_l_reg <= rd_l_x;
                end else begin
                    idx_reg <= idx_p1;
                end
            end
            OP_PRV: begin
                prv_end_reg <= rd_s_x + rd_l_x;
                prv_l_reg   <= rd_l_x;
            end
            OP_F_NEXT: mlen_reg <= nxt_l_reg + rs_reg;
            OP_F_MRG:  j_reg    <= idx_reg;
            OP_F_INS: begin
                ins_idx_reg <= idx_reg;
                ins_s_reg   <= off_reg;
                ins_l_reg   <= rs_reg;
                j_reg       <= cnt_reg;
            end
            OP_EMIT: begin
                out_st_reg    <= st_reg;
                out_grant_reg <= grant_reg[SIZE_W-1:0];
            end
            default: begin
                idx_reg <= idx_reg;
            end
        endcase
    end

    // Flags for the controller
    always_comb begin
        stat_o.is_free  = type_reg;
        stat_o.pre_done = disp_done;
        stat_o.idx_end  = (idx_reg == cnt_reg);
        stat_o.idx_zero = (idx_reg == '0);
        stat_o.fit      = fit_reg;
        stat_o.bef_nz   = (bef_reg != '0);
        stat_o.aft_nz   = (aft_reg != '0);
        stat_o.full     = full;
        stat_o.ins_done = (j_reg <= ins_idx_reg);
        stat_o.del_done = ({1'b0, j_reg} + 1'b1) >= {1'b0, cnt_reg};
        stat_o.gt       = (rd_s_x > off_reg);
        stat_o.mnext    = (idx_reg != cnt_reg) && (fend_reg == nxt_s_reg);
        stat_o.mprev    = (idx_reg != '0) && (off_reg == prv_end_reg);
        stat_o.bump_ok  = bump_ok_reg;
        stat_o.gap      = gap_reg;
    end

    assign status_o           = out_st_reg;
    assign granted_offset_i_o = out_grant_reg;

endmodule

>>> rtl/core/ffca_ctrl.sv
// ============================================================================
// ffca_ctrl
// Allocator controller: one-hot sequencer that takes a request, walks the
// extent table through the datapath and hands the result to the output.
// ============================================================================
module ffca_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output ffca_pkg::dp_op_t   op_o,
    input  ffca_pkg::dp_stat_t stat_i
);
    import ffca_pkg::*;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_DISP    = 21'h000002,
        S_A_CHK   = 21'h000004,
        S_A_E1    = 21'h000008,
        S_A_E2    = 21'h000010,
        S_A_E3    = 21'h000020,
        S_A_ACT   = 21'h000040,
        S_B1      = 21'h000080,
        S_B2      = 21'h000100,
        S_B3      = 21'h000200,
        S_INS_CHK = 21'h000400,
        S_INS_MV  = 21'h000800,
        S_DEL_CHK = 21'h001000,
        S_DEL_MV  = 21'h002000,
        S_F_CHK   = 21'h004000,
        S_F_CMP   = 21'h008000,
        S_F_PRV   = 21'h010000,
        S_F_PRV2  = 21'h020000,
        S_F_ACT   = 21'h040000,
        S_F_MRG   = 21'h080000,
        S_FIN     = 21'h100000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

    // Sequence the request through the datapath
    always_comb begin
        state_next = state_reg;
        op_o       = OP_NONE;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_o       = OP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP: begin
                op_o = OP_DISP;
                if (stat_i.pre_done) begin
                    state_next = S_FIN;
                end else if (stat_i.is_free) begin
                    state_next = S_F_CHK;
                end else begin
                    state_next = S_A_CHK;
                end
            end
            S_A_CHK: begin
                if (stat_i.idx_end) begin
                    state_next = S_B1;
                end else begin
                    op_o       = OP_RD_IDX;
                    state_next = S_A_E1;
                end
            end
            S_A_E1: begin
                op_o       = OP_E1;
                state_next = S_A_E2;
            end
            S_A_E2: begin
                op_o       = OP_E2;
                state_next = S_A_E3;
            end
            S_A_E3: begin
                if (stat_i.fit) begin
                    op_o       = OP_FIT;
                    state_next = S_A_ACT;
                end else begin
                    op_o       = OP_IDX_INC;
                    state_next = S_A_CHK;
                end
            end
            S_A_ACT: begin
                if (stat_i.bef_nz) begin
                    op_o       = OP_SPLIT;
                    state_next = (stat_i.aft_nz && !stat_i.full) ? S_INS_CHK : S_FIN;
                end else if (stat_i.aft_nz) begin
                    op_o       = OP_SHRINK;
                    state_next = S_FIN;
                end else begin
                    op_o       = OP_DEL_SETUP;
                    state_next = S_DEL_CHK;
                end
            end
            S_INS_CHK: begin
                if (stat_i.ins_done) begin
                    op_o       = OP_INS_WR;
                    state_next = S_FIN;
                end else begin
                    op_o       = OP_RD_JM1;
                    state_next = S_INS_MV;
                end
            end
            S_INS_MV: begin
                op_o       = OP_MV_UP;
                state_next = S_INS_CHK;
            end
            S_DEL_CHK: begin
                if (stat_i.del_done) begin
                    op_o       = OP_DEL_END;
                    state_next = S_FIN;
                end else begin
                    op_o       = OP_RD_JP1;
                    state_next = S_DEL_MV;
                end
            end
            S_DEL_MV: begin
                op_o       = OP_MV_DN;
                state_next = S_DEL_CHK;
            end
            S_B1: begin
                op_o       = OP_B1;
                state_next = S_B2;
            end
            S_B2: begin
                op_o       = OP_B2;
                state_next = S_B3;
            end
            S_B3: begin
                op_o = OP_B3;
                if (stat_i.bump_ok && stat_i.gap && !stat_i.full) begin
                    state_next = S_INS_CHK;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_F_CHK: begin
                if (stat_i.idx_end) begin
                    state_next = S_F_PRV;
                end else begin
                    op_o       = OP_RD_IDX;
                    state_next = S_F_CMP;
                end
            end
            S_F_CMP: begin
                op_o       = OP_FCMP;
                state_next = stat_i.gt ? S_F_PRV : S_F_CHK;
            end
            S_F_PRV: begin
                if (stat_i.idx_zero) begin
                    state_next = S_F_ACT;
                end else begin
                    op_o       = OP_RD_IDXM1;
                    state_next = S_F_PRV2;
                end
            end
            S_F_PRV2: begin
                op_o       = OP_PRV;
                state_next = S_F_ACT;
            end
            S_F_ACT: begin
                if (stat_i.mnext) begin
                    op_o       = OP_F_NEXT;
                    state_next = stat_i.mprev ? S_F_MRG : S_FIN;
                end else if (stat_i.mprev) begin
                    op_o       = OP_F_PREV;
                    state_next = S_FIN;
                end else begin
                    op_o       = OP_F_INS;
                    state_next = S_INS_CHK;
                end
            end
            S_F_MRG: begin
                op_o       = OP_F_MRG;
                state_next = S_DEL_CHK;
            end
            S_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    op_o       = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (op_o == OP_EMIT) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> rtl/core/ffca_checker.sv
// ============================================================================
// ffca_checker
// Port-level checks for the allocator: one item in flight, stable stalled
// results, legal status codes and a zero offset on failed requests.
// ============================================================================
module ffca_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [39:0]  m_axis_tdata,
    input logic [2:0]   m_axis_tuser
);
    import ffca_pkg::*;

    // Hold off the next item right after one is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while previous one still in work");

    // Hold a stalled result
    a_result_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status stays within the defined codes
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> m_axis_tuser <= ST_FREEDROP)
        else $error("undefined status code");

    // Back, no-space and dropped-free results carry no offset
    a_zero_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser != ST_OK && m_axis_tuser != ST_FRAG
            |-> m_axis_tdata == '0)
        else $error("offset returned on a failed request");

endmodule

bind first_fit_coalescing_allocator_unit ffca_checker u_ffca_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
